FILE: src/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared constants and codes for the bounded sequence store: field widths,
// operation codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

   // default number of stored values
   localparam int BSS_DEPTH = 32;

   // fixed field widths
   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 3;
   localparam int POS_W   = 6;
   localparam int INDEX_W = 5;
   localparam int STAT_W  = 3;
   localparam int FILL_W  = 6;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_FRONT  = 3'd0,
      FN_PUSH_REAR   = 3'd1,
      FN_INSERT_AT   = 3'd2,
      FN_SORTED_INS  = 3'd3,
      FN_POP_FRONT   = 3'd4,
      FN_POP_REAR    = 3'd5,
      FN_REMOVE_AT   = 3'd6,
      FN_FIND        = 3'd7
   } func_type;

   // status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_BADPOS   = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

endpackage

`default_nettype wire

FILE: src/bss_mem.sv
// ----------------------------------------------------------------------------
// bss_mem
// Slot memory: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_mem
   import bss_pkg::*;
#(
   parameter int DEPTH = BSS_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= wr_data;
      end
   end

   // read one word, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// Sequencer for the bounded sequence store: decodes a request, walks the
// slot memory to scan, open a gap or close a gap, keeps the fill count and
// drives the one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_ctrl
   import bss_pkg::*;
#(
   parameter int DEPTH = BSS_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [FUNC_W-1:0]         req_func,
   input  wire logic signed [DATA_W-1:0]  req_value,
   input  wire logic [POS_W-1:0]          req_position,
   // result
   output logic                           rsp_valid,
   output logic signed [DATA_W-1:0]       rsp_data_out,
   output logic [INDEX_W-1:0]             rsp_found_index,
   output logic [STAT_W-1:0]              rsp_status,
   output logic [FILL_W-1:0]              rsp_fill_count,
   // slot memory
   output logic                           mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]       mem_wr_addr,
   output logic [DATA_W-1:0]              mem_wr_data,
   output logic                           mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]       mem_rd_addr,
   input  wire logic [DATA_W-1:0]         mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UP,
      ST_DOWN
   } state_type;

   state_type                 state_ff, state_in;
   func_type                  op_ff, op_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic signed [DATA_W-1:0]  val_ff, val_in;
   logic [CW-1:0]             tgt_ff, tgt_in;
   logic [CW-1:0]             wp_ff, wp_in;
   logic [CW-1:0]             rp_ff, rp_in;
   logic [CW-1:0]             ci_ff, ci_in;
   logic                      pend_ff, pend_in;
   logic                      first_ff, first_in;
   logic                      vld_ff, vld_in;
   logic signed [DATA_W-1:0]  data_ff, data_in;
   logic [INDEX_W-1:0]        fidx_ff, fidx_in;
   status_type                stat_ff, stat_in;

   logic [XW-1:0]             cnt_x, pos_x, pm1_x, ci_x;
   logic [CW-1:0]             wm1, wm2, idx_req;
   logic                      full, empty, ins_ok, rm_ok, hit;

   // request decode helpers
   assign cnt_x   = XW'(cnt_ff);
   assign pos_x   = XW'(req_position);
   assign pm1_x   = pos_x - XW'(1);
   assign idx_req = pm1_x[CW-1:0];
   assign ci_x    = XW'(ci_ff);
   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign ins_ok  = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
   assign rm_ok   = (pos_x != '0) && (pos_x <= cnt_x);
   assign wm1     = wp_ff - CW'(1);
   assign wm2     = wp_ff - CW'(2);

   // compare the word that arrives from memory during a scan
   assign hit = pend_ff &&
                ((op_ff == FN_FIND) ? (mem_rd_data == val_ff)
                                    : ($signed(mem_rd_data) > val_ff));

   // next state, memory strobes and result
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      cnt_in      = cnt_ff;
      val_in      = val_ff;
      tgt_in      = tgt_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      ci_in       = ci_ff;
      pend_in     = pend_ff;
      first_in    = first_ff;
      vld_in      = 1'b0;
      data_in     = data_ff;
      fidx_in     = fidx_ff;
      stat_in     = stat_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = func_type'(req_func);
               val_in   = req_value;
               data_in  = '0;
               fidx_in  = '0;
               stat_in  = STAT_OK;
               pend_in  = 1'b0;
               first_in = 1'b1;
               ci_in    = '0;
               rp_in    = '0;
               wp_in    = cnt_ff;
               unique case (func_type'(req_func))
                  FN_PUSH_FRONT, FN_PUSH_REAR, FN_INSERT_AT, FN_SORTED_INS: begin
                     priority if (full) begin
                        stat_in = STAT_FULL;
                        vld_in  = 1'b1;
                     end else if (func_type'(req_func) == FN_PUSH_FRONT) begin
                        tgt_in   = '0;
                        state_in = ST_UP;
                     end else if (func_type'(req_func) == FN_PUSH_REAR) begin
                        tgt_in   = cnt_ff;
                        state_in = ST_UP;
                     end else if (func_type'(req_func) == FN_INSERT_AT) begin
                        if (ins_ok) begin
                           tgt_in   = idx_req;
                           state_in = ST_UP;
                        end else begin
                           stat_in = STAT_BADPOS;
                           vld_in  = 1'b1;
                        end
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FN_POP_FRONT, FN_POP_REAR: begin
                     if (empty) begin
                        stat_in = STAT_EMPTY;
                        vld_in  = 1'b1;
                     end else begin
                        rp_in    = (func_type'(req_func) == FN_POP_FRONT) ?
                                   '0 : (cnt_ff - CW'(1));
                        wp_in    = rp_in;
                        state_in = ST_DOWN;
                     end
                  end
                  FN_REMOVE_AT: begin
                     priority if (empty) begin
                        stat_in = STAT_EMPTY;
                        vld_in  = 1'b1;
                     end else if (!rm_ok) begin
                        stat_in = STAT_BADPOS;
                        vld_in  = 1'b1;
                     end else begin
                        rp_in    = idx_req;
                        wp_in    = idx_req;
                        state_in = ST_DOWN;
                     end
                  end
                  FN_FIND: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end

         // walk the entries from the front, one read per cycle
         ST_SCAN: begin
            priority if (hit) begin
               if (op_ff == FN_FIND) begin
                  fidx_in  = ci_x[INDEX_W-1:0];
                  vld_in   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  tgt_in   = ci_ff;
                  wp_in    = cnt_ff;
                  pend_in  = 1'b0;
                  state_in = ST_UP;
               end
            end else if (rp_ff == cnt_ff) begin
               if (op_ff == FN_FIND) begin
                  stat_in  = STAT_NOTFOUND;
                  vld_in   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  tgt_in   = cnt_ff;
                  wp_in    = cnt_ff;
                  pend_in  = 1'b0;
                  state_in = ST_UP;
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rp_ff[AW-1:0];
               rp_in       = rp_ff + CW'(1);
               ci_in       = ci_ff + CW'(pend_ff);
               pend_in     = 1'b1;
            end
         end

         // open a gap: move entries up one slot from the rear, then drop value in
         ST_UP: begin
            priority if (wp_ff == tgt_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = tgt_ff[AW-1:0];
               mem_wr_data = val_ff;
               cnt_in      = cnt_ff + CW'(1);
               vld_in      = 1'b1;
               state_in    = ST_IDLE;
            end else if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wp_ff[AW-1:0];
               mem_wr_data = mem_rd_data;
               wp_in       = wm1;
               if (wm1 != tgt_ff) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = wm2[AW-1:0];
                  pend_in     = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = wm1[AW-1:0];
               pend_in     = 1'b1;
            end
         end

         // close a gap: capture the removed word, move later entries down
         ST_DOWN: begin
            if (pend_ff) begin
               if (first_ff) begin
                  data_in  = mem_rd_data;
                  first_in = 1'b0;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wp_ff[AW-1:0];
                  mem_wr_data = mem_rd_data;
                  wp_in       = wp_ff + CW'(1);
               end
            end
            if (rp_ff == cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               pend_in  = 1'b0;
               vld_in   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rp_ff[AW-1:0];
               rp_in       = rp_ff + CW'(1);
               pend_in     = 1'b1;
            end
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         first_ff <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         first_ff <= first_in;
         vld_ff   <= vld_in;
         op_ff    <= op_in;
         val_ff   <= val_in;
         tgt_ff   <= tgt_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         ci_ff    <= ci_in;
         data_ff  <= data_in;
         fidx_ff  <= fidx_in;
         stat_ff  <= stat_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = vld_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_status      = stat_ff;
   assign rsp_fill_count  = cnt_x[FILL_W-1:0];

`ifndef SYNTHESIS
   // fill count never passes the capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("fill count above capacity");

   // a shift never reads the slot it writes in the same cycle
   a_no_same_slot: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("read and write hit the same slot");

   // the result strobe comes only once the sequencer is back at rest
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while busy");

   // an accepted request either keeps the block busy or answers at once
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || vld_ff))
      else $error("request accepted but neither busy nor answered");

   // the count moves only together with a result
   a_cnt_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |-> vld_ff)
      else $error("fill count changed without a result");
`endif

endmodule

`default_nettype wire

FILE: src/bounded_sequence_store_unit.sv
// ----------------------------------------------------------------------------
// bounded_sequence_store_unit
// Ordered store of up to DEPTH signed 32-bit values with push and pop at
// both ends, positional insert and remove, sorted insert and find.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with rsp_valid high, and the receiver
// cannot stall it, so capture it on that cycle. The values sit in one slot
// memory with a registered read, and every walk over it moves one entry per
// cycle through that single read port and single write port. Push rear and
// pop rear touch only the rear slot; push front, insert at, pop front and
// remove at move every entry behind the position; find scans from the front
// until it hits or reaches the fill count, and sorted insert scans, then
// opens a gap. An error answer comes without any walk.
// busy falls on the cycle the result is shown, and a new request may be
// given on that same cycle. No clearing pass is needed after reset: entries
// beyond the fill count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_sequence_store_unit
   import bss_pkg::*;
#(
   parameter int DEPTH = BSS_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [FUNC_W-1:0]         req_func,
   input  wire logic signed [DATA_W-1:0]  req_value,
   input  wire logic [POS_W-1:0]          req_position,
   output logic                           rsp_valid,
   output logic signed [DATA_W-1:0]       rsp_data_out,
   output logic [INDEX_W-1:0]             rsp_found_index,
   output logic [STAT_W-1:0]              rsp_status,
   output logic [FILL_W-1:0]              rsp_fill_count
);

   localparam int AW = $clog2(DEPTH);

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   // sequencer
   bss_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_data_out    (rsp_data_out),
      .rsp_found_index (rsp_found_index),
      .rsp_status      (rsp_status),
      .rsp_fill_count  (rsp_fill_count),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   // slot memory
   bss_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire
